[src/chme_pkg.sv]
// Shared constants and field layout for the coarse height map engine.
`default_nettype none

package chme_pkg;

  // Defaults for the grid geometry parameters.
  localparam int CELL_X_DEF    = 16;
  localparam int CELL_Y_DEF    = 16;
  localparam int GRID_COLS_DEF = 64;
  localparam int GRID_ROWS_DEF = 64;

  // Operation codes carried in the opcode field.
  localparam logic [1:0] OP_MAX  = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_AREA = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_LENGTH = 1'b0;
  localparam logic CFG_WIDTH  = 1'b1;

  // Field widths.
  localparam int OP_W     = 2;
  localparam int COORD_W  = 10;
  localparam int HEIGHT_W = 16;
  localparam int AREA_W   = 21;
  localparam int EXT_W    = 11;
  localparam int IN_W     = 64;
  localparam int OUT_W    = 40;

  // Reciprocal divide: dividend up to 2047 + 255, divisor up to 256.
  localparam int DVD_W       = 12;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 25;
  // Pallet positions of cell edges, up to 256 * 256.
  localparam int POS_W = 17;
  // Span of a rectangle inside one cell, at most 1024.
  localparam int SPAN_W = 11;

endpackage

`default_nettype wire

[src/chme_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module chme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[src/coarse_height_map_engine.sv]
// Top level of the coarse height map engine: sequencer, reciprocal divide and grid sweep.
`default_nettype none

// Keeps a GRID_COLS x GRID_ROWS grid of 16-bit cell heights in one RAM. After
// reset a clearing pass writes every cell to zero, one cell a cycle; no item
// is accepted until it ends (config writes are taken throughout). Items are
// then taken one at a time: one shared reciprocal multiplier maps the
// rectangle and the pallet extents to cell indices, one quotient after
// another, a span state settles the covered span, and a sweep over the
// covered cells runs at one cell per cycle through the RAM read port,
// followed by a drain of the read stage (and of the area stage in the area
// pass). An add or max query makes one sweep, an area query two (max, then
// area). An item with no covered cell skips the sweep. The result goes into
// an output register, so the next item may be taken while it waits; a
// finished item holds in the done state while the previous result is not
// taken.
module coarse_height_map_engine #(
  parameter int CELL_X    = chme_pkg::CELL_X_DEF,
  parameter int CELL_Y    = chme_pkg::CELL_Y_DEF,
  parameter int GRID_COLS = chme_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = chme_pkg::GRID_ROWS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // fields from bit 0: opcode, x_low, y_low, x_high, y_high, new_height
  input  wire logic [chme_pkg::IN_W-1:0]  s_axis_tdata,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // fields from bit 0: max_height, top_area
  output logic      [chme_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [chme_pkg::EXT_W-1:0] cfg_wdata_i
);

  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int DVD_W = chme_pkg::DVD_W;
  localparam int RSH   = chme_pkg::RECIP_SHIFT;
  localparam int RCW   = chme_pkg::RECIP_W;
  localparam int QP_W  = DVD_W + RSH;
  localparam int POS_W = chme_pkg::POS_W;
  localparam int SPAN_W = chme_pkg::SPAN_W;
  localparam int HW    = chme_pkg::HEIGHT_W;
  localparam int CRW   = chme_pkg::COORD_W;

  // reciprocals rounded up; exact for every dividend below 2**DVD_W
  localparam logic [RCW-1:0] RECIP_X = RCW'(((1 << RSH) + CELL_X - 1) / CELL_X);
  localparam logic [RCW-1:0] RECIP_Y = RCW'(((1 << RSH) + CELL_Y - 1) / CELL_Y);

  // Divider operand slots.
  localparam logic [2:0] D_XL = 3'd0;
  localparam logic [2:0] D_XH = 3'd1;
  localparam logic [2:0] D_LN = 3'd2;
  localparam logic [2:0] D_YL = 3'd3;
  localparam logic [2:0] D_YH = 3'd4;
  localparam logic [2:0] D_WD = 3'd5;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SPAN,
    S_SWEEP,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  logic [chme_pkg::EXT_W-1:0] plen_q, plen_d, pwid_q, pwid_d;
  logic [chme_pkg::OP_W-1:0]  op_q, op_d;
  logic [CRW-1:0]             xl_q, xl_d, yl_q, yl_d, xh_q, xh_d, yh_q, yh_d;
  logic [HW-1:0]              hgt_q, hgt_d;

  logic [2:0]       div_sel_q, div_sel_d;
  logic [DVD_W-1:0] quo_q [6];
  logic [DVD_W-1:0] quo_d [6];

  logic [CW-1:0]    cx1_q, cx1_d, cx2_q, cx2_d, cx_q, cx_d;
  logic [RW-1:0]    cy1_q, cy1_d, cy2_q, cy2_d, cy_q, cy_d;
  logic [AW-1:0]    rbase_q, rbase_d;
  logic [POS_W-1:0] xlo_q, xlo_d, xhi_q, xhi_d, ylo_q, ylo_d, yhi_q, yhi_d;
  logic [POS_W-1:0] xb1_q, xb1_d, xb1h_q, xb1h_d;
  logic             pass_q, pass_d;

  logic              vb_q, vb_d, vc_q, vc_d, hit_q, hit_d;
  logic [AW-1:0]     addr_b_q, addr_b_d;
  logic [SPAN_W-1:0] dx_b_q, dx_b_d, dy_b_q, dy_b_d;
  logic [2*SPAN_W-1:0] prod_q, prod_d;

  logic [HW-1:0]                 top_q, top_d;
  logic [chme_pkg::AREA_W-1:0]   area_q, area_d;
  logic [AW-1:0]                 clr_q, clr_d;
  logic                          mval_q, mval_d;
  logic [HW-1:0]                 res_max_q, res_max_d;
  logic [chme_pkg::AREA_W-1:0]   res_area_q, res_area_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [HW-1:0] mem_wdata, mem_rdata;

  // divide datapath
  logic [DVD_W-1:0] dvd_op;
  logic [RCW-1:0]   recip;
  logic [QP_W-1:0]  quo_prod;

  // span datapath
  logic [DVD_W-1:0] cols, rows, bx, by;
  logic             covered;

  // per-cell overlap
  logic [POS_W-1:0] ix1, ix2, iy1, iy2;
  logic [SPAN_W-1:0] dx, dy;

  chme_ram #(
    .WIDTH (HW),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    case (div_sel_q)
      D_XL:    dvd_op = DVD_W'(xl_q);
      D_XH:    dvd_op = DVD_W'(xh_q);
      D_LN:    dvd_op = DVD_W'(plen_q) + DVD_W'(CELL_X - 1);
      D_YL:    dvd_op = DVD_W'(yl_q);
      D_YH:    dvd_op = DVD_W'(yh_q);
      D_WD:    dvd_op = DVD_W'(pwid_q) + DVD_W'(CELL_Y - 1);
      default: dvd_op = '0;
    endcase
    recip    = (div_sel_q < D_YL) ? RECIP_X : RECIP_Y;
    quo_prod = QP_W'(dvd_op) * QP_W'(recip);
  end

  always_comb begin
    cols = (quo_q[D_LN] > DVD_W'(GRID_COLS)) ? DVD_W'(GRID_COLS) : quo_q[D_LN];
    rows = (quo_q[D_WD] > DVD_W'(GRID_ROWS)) ? DVD_W'(GRID_ROWS) : quo_q[D_WD];
    bx   = (quo_q[D_XH] > cols - 1'b1) ? cols - 1'b1 : quo_q[D_XH];
    by   = (quo_q[D_YH] > rows - 1'b1) ? rows - 1'b1 : quo_q[D_YH];
    covered = (cols != '0) && (rows != '0) &&
              (quo_q[D_XL] <= bx) && (quo_q[D_YL] <= by);
  end

  always_comb begin
    ix1 = (xlo_q < POS_W'(xl_q)) ? POS_W'(xl_q) : xlo_q;
    ix2 = (xhi_q > POS_W'(xh_q) + 1'b1) ? POS_W'(xh_q) + 1'b1 : xhi_q;
    iy1 = (ylo_q < POS_W'(yl_q)) ? POS_W'(yl_q) : ylo_q;
    iy2 = (yhi_q > POS_W'(yh_q) + 1'b1) ? POS_W'(yh_q) + 1'b1 : yhi_q;
    dx  = (ix1 < ix2) ? SPAN_W'(ix2 - ix1) : '0;
    dy  = (iy1 < iy2) ? SPAN_W'(iy2 - iy1) : '0;
  end

  assign mem_raddr = rbase_q + AW'(cx_q);

  always_comb begin
    state_d    = state_q;
    plen_d     = plen_q;
    pwid_d     = pwid_q;
    op_d       = op_q;
    xl_d       = xl_q;
    yl_d       = yl_q;
    xh_d       = xh_q;
    yh_d       = yh_q;
    hgt_d      = hgt_q;
    div_sel_d  = div_sel_q;
    quo_d      = quo_q;
    cx1_d      = cx1_q;
    cx2_d      = cx2_q;
    cx_d       = cx_q;
    cy1_d      = cy1_q;
    cy2_d      = cy2_q;
    cy_d       = cy_q;
    rbase_d    = rbase_q;
    xlo_d      = xlo_q;
    xhi_d      = xhi_q;
    ylo_d      = ylo_q;
    yhi_d      = yhi_q;
    xb1_d      = xb1_q;
    xb1h_d     = xb1h_q;
    pass_d     = pass_q;
    vb_d       = 1'b0;
    addr_b_d   = addr_b_q;
    dx_b_d     = dx_b_q;
    dy_b_d     = dy_b_q;
    vc_d       = 1'b0;
    hit_d      = hit_q;
    prod_d     = prod_q;
    top_d      = top_q;
    area_d     = area_q;
    clr_d      = clr_q;
    mval_d     = mval_q;
    res_max_d  = res_max_q;
    res_area_d = res_area_q;
    mem_we     = 1'b0;
    mem_waddr  = addr_b_q;
    mem_wdata  = hgt_q;

    if (cfg_we_i) begin
      if (cfg_idx_i == chme_pkg::CFG_LENGTH) begin
        plen_d = cfg_wdata_i;
      end else begin
        pwid_d = cfg_wdata_i;
      end
    end

    if (mval_q && m_axis_tready) begin
      mval_d = 1'b0;
    end

    // stage B: read data is back
    if (vb_q) begin
      if (!pass_q && (op_q == chme_pkg::OP_MAX || op_q == chme_pkg::OP_AREA)) begin
        if (mem_rdata > top_q) begin
          top_d = mem_rdata;
        end
      end
      if (op_q == chme_pkg::OP_ADD && mem_rdata < hgt_q) begin
        mem_we = 1'b1;
      end
      if (pass_q) begin
        vc_d   = 1'b1;
        hit_d  = (mem_rdata == top_q);
        prod_d = dx_b_q * dy_b_q;
      end
    end

    // stage C: accumulate area
    if (vc_q && hit_q) begin
      area_d = area_q + prod_q[chme_pkg::AREA_W-1:0];
    end

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d      = s_axis_tdata[1:0];
          xl_d      = s_axis_tdata[11:2];
          yl_d      = s_axis_tdata[21:12];
          xh_d      = s_axis_tdata[31:22];
          yh_d      = s_axis_tdata[41:32];
          hgt_d     = s_axis_tdata[57:42];
          div_sel_d = D_XL;
          top_d     = '0;
          area_d    = '0;
          pass_d    = 1'b0;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        // one quotient per cycle through the shared multiplier
        quo_d[div_sel_q] = DVD_W'(quo_prod >> RSH);
        if (div_sel_q == D_WD) begin
          div_sel_d = D_XL;
          state_d   = S_SPAN;
        end else begin
          div_sel_d = div_sel_q + 1'b1;
        end
      end
      S_SPAN: begin
        if (!covered || op_q == chme_pkg::OP_NONE) begin
          state_d = S_DONE;
        end else begin
          cx1_d   = quo_q[D_XL][CW-1:0];
          cx2_d   = bx[CW-1:0];
          cy1_d   = quo_q[D_YL][RW-1:0];
          cy2_d   = by[RW-1:0];
          cx_d    = quo_q[D_XL][CW-1:0];
          cy_d    = quo_q[D_YL][RW-1:0];
          rbase_d = AW'(32'(quo_q[D_YL][RW-1:0]) * GRID_COLS);
          xb1_d   = POS_W'(32'(quo_q[D_XL][CW-1:0]) * CELL_X);
          xb1h_d  = POS_W'((32'(quo_q[D_XL][CW-1:0]) + 1) * CELL_X);
          xlo_d   = POS_W'(32'(quo_q[D_XL][CW-1:0]) * CELL_X);
          xhi_d   = POS_W'((32'(quo_q[D_XL][CW-1:0]) + 1) * CELL_X);
          ylo_d   = POS_W'(32'(quo_q[D_YL][RW-1:0]) * CELL_Y);
          yhi_d   = POS_W'((32'(quo_q[D_YL][RW-1:0]) + 1) * CELL_Y);
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        vb_d     = 1'b1;
        addr_b_d = mem_raddr;
        dx_b_d   = dx;
        dy_b_d   = dy;
        if (cx_q == cx2_q) begin
          cx_d  = cx1_q;
          xlo_d = xb1_q;
          xhi_d = xb1h_q;
          if (cy_q == cy2_q) begin
            state_d = S_DRAIN;
          end else begin
            cy_d    = cy_q + 1'b1;
            rbase_d = rbase_q + AW'(GRID_COLS);
            ylo_d   = ylo_q + POS_W'(CELL_Y);
            yhi_d   = yhi_q + POS_W'(CELL_Y);
          end
        end else begin
          cx_d  = cx_q + 1'b1;
          xlo_d = xlo_q + POS_W'(CELL_X);
          xhi_d = xhi_q + POS_W'(CELL_X);
        end
      end
      S_DRAIN: begin
        if (!vb_q && !vc_q) begin
          if (op_q == chme_pkg::OP_AREA && !pass_q) begin
            pass_d  = 1'b1;
            state_d = S_SPAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!mval_q || m_axis_tready) begin
          res_max_d  = top_q;
          res_area_d = area_q;
          mval_d     = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      plen_q    <= 11'd1024;
      pwid_q    <= 11'd1024;
      div_sel_q <= D_XL;
      pass_q    <= 1'b0;
      vb_q      <= 1'b0;
      vc_q      <= 1'b0;
      clr_q     <= '0;
      mval_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      plen_q    <= plen_d;
      pwid_q    <= pwid_d;
      div_sel_q <= div_sel_d;
      pass_q    <= pass_d;
      vb_q      <= vb_d;
      vc_q      <= vc_d;
      clr_q     <= clr_d;
      mval_q    <= mval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    xl_q       <= xl_d;
    yl_q       <= yl_d;
    xh_q       <= xh_d;
    yh_q       <= yh_d;
    hgt_q      <= hgt_d;
    quo_q      <= quo_d;
    cx1_q      <= cx1_d;
    cx2_q      <= cx2_d;
    cx_q       <= cx_d;
    cy1_q      <= cy1_d;
    cy2_q      <= cy2_d;
    cy_q       <= cy_d;
    rbase_q    <= rbase_d;
    xlo_q      <= xlo_d;
    xhi_q      <= xhi_d;
    ylo_q      <= ylo_d;
    yhi_q      <= yhi_d;
    xb1_q      <= xb1_d;
    xb1h_q     <= xb1h_d;
    addr_b_q   <= addr_b_d;
    dx_b_q     <= dx_b_d;
    dy_b_q     <= dy_b_d;
    hit_q      <= hit_d;
    prod_q     <= prod_d;
    top_q      <= top_d;
    area_q     <= area_d;
    res_max_q  <= res_max_d;
    res_area_q <= res_area_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = {3'b000, res_area_q, res_max_q};

`ifndef ASSERT_OFF
  // the grid is only written by the clearing pass or an add
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q != S_CLEAR) |-> (op_q == chme_pkg::OP_ADD))
    else $error("grid written outside add");

  // the sweep stays inside the covered span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> (cx_q >= cx1_q && cx_q <= cx2_q &&
                              cy_q >= cy1_q && cy_q <= cy2_q))
    else $error("sweep index outside span");

  // the maximum is frozen while the area pass compares against it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pass_q && (vb_q || vc_q)) |=> $stable(top_q))
    else $error("max height changed during area pass");

  // a result appears only out of the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mval_q) |-> ($past(state_q) == S_DONE))
    else $error("result without finished item");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the coarse height map engine: region ops under config sweeps.
module tb;

  localparam int CELLS        = chme_pkg::GRID_COLS_DEF * chme_pkg::GRID_ROWS_DEF;
  // worst item: divisions plus two full sweeps
  localparam int ITEM_LATENCY = 80 + 2 * (CELLS + 4);
  // clearing pass after reset plus the slowest item, with margin
  localparam int STALL_LIMIT  = 4 * (CELLS + ITEM_LATENCY + 8);

  localparam int CX    = chme_pkg::CELL_X_DEF;
  localparam int CY    = chme_pkg::CELL_Y_DEF;
  localparam int GCOLS = chme_pkg::GRID_COLS_DEF;
  localparam int GROWS = chme_pkg::GRID_ROWS_DEF;
  localparam int HGT_W = chme_pkg::HEIGHT_W;
  localparam int CRD_W = chme_pkg::COORD_W;
  localparam int AR_W  = chme_pkg::AREA_W;
  localparam int EX_W  = chme_pkg::EXT_W;

  typedef struct packed {
    logic [HGT_W-1:0]          h;
    logic [CRD_W-1:0]          yh;
    logic [CRD_W-1:0]          xh;
    logic [CRD_W-1:0]          yl;
    logic [CRD_W-1:0]          xl;
    logic [chme_pkg::OP_W-1:0] op;
  } region_op_t;

  typedef struct packed {
    logic [AR_W-1:0]  area;
    logic [HGT_W-1:0] top;
  } height_result_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  // fields from bit 0: opcode, x_low, y_low, x_high, y_high, new_height
  logic [chme_pkg::IN_W-1:0]  s_axis_tdata  = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  // fields from bit 0: max_height, top_area
  logic [chme_pkg::OUT_W-1:0] m_axis_tdata;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic                       cfg_we_i      = 1'b0;
  logic                       cfg_idx_i     = chme_pkg::CFG_LENGTH;
  logic [EX_W-1:0]            cfg_wdata_i   = '0;

  coarse_height_map_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow of the grid and the pallet registers
  logic [HGT_W-1:0] cell_h [CELLS];
  logic [EX_W-1:0]  pallet_len = 11'd1024;
  logic [EX_W-1:0]  pallet_wid = 11'd1024;

  region_op_t     pending_ops [$];
  height_result_t expected_results [$];
  region_op_t     cur_op;
  int unsigned    tx_wait = 0;
  int unsigned    rx_wait = 0;
  bit             tx_burst = 1'b0;
  bit             rx_burst = 1'b0;
  int unsigned    mismatch_count = 0;
  int unsigned    ops_accepted = 0;
  int unsigned    results_checked = 0;
  int unsigned    area_hits = 0;
  int unsigned    cfg_settings = 1;
  int unsigned    idle_cycles = 0;

  function automatic bit cell_range(input int unsigned lo, input int unsigned hi,
                                    input int unsigned cell_sz, input int unsigned used,
                                    output int unsigned c1, output int unsigned c2);
    if (used == 0) return 1'b0;
    c1 = lo / cell_sz;
    c2 = hi / cell_sz;
    if (c2 > used - 1) c2 = used - 1;
    return c1 <= c2;
  endfunction

  task automatic apply_region_op(input region_op_t it, output height_result_t res);
    int unsigned cols, rows, cx1, cx2, cy1, cy2, top, area, ix1, ix2, iy1, iy2, idx;
    bit          covered;
    cols = (pallet_len + CX - 1) / CX;
    if (cols > GCOLS) cols = GCOLS;
    rows = (pallet_wid + CY - 1) / CY;
    if (rows > GROWS) rows = GROWS;
    cx1 = 0; cx2 = 0; cy1 = 0; cy2 = 0;
    top = 0;
    area = 0;
    covered = cell_range(it.xl, it.xh, CX, cols, cx1, cx2) &&
              cell_range(it.yl, it.yh, CY, rows, cy1, cy2);
    if (covered && it.op == chme_pkg::OP_ADD) begin
      for (int unsigned cy = cy1; cy <= cy2; cy++)
        for (int unsigned cx = cx1; cx <= cx2; cx++) begin
          idx = cy * GCOLS + cx;
          if (cell_h[idx] < it.h) cell_h[idx] = it.h;
        end
    end else if (covered && (it.op == chme_pkg::OP_MAX || it.op == chme_pkg::OP_AREA)) begin
      for (int unsigned cy = cy1; cy <= cy2; cy++)
        for (int unsigned cx = cx1; cx <= cx2; cx++)
          if (cell_h[cy * GCOLS + cx] > top) top = cell_h[cy * GCOLS + cx];
      if (it.op == chme_pkg::OP_AREA) begin
        for (int unsigned cy = cy1; cy <= cy2; cy++)
          for (int unsigned cx = cx1; cx <= cx2; cx++) begin
            if (cell_h[cy * GCOLS + cx] != top) continue;
            // clip the cell to the rectangle, upper bounds exclusive
            ix1 = cx * CX;
            ix2 = (cx + 1) * CX;
            iy1 = cy * CY;
            iy2 = (cy + 1) * CY;
            if (ix1 < it.xl) ix1 = it.xl;
            if (iy1 < it.yl) iy1 = it.yl;
            if (ix2 > it.xh + 1) ix2 = it.xh + 1;
            if (iy2 > it.yh + 1) iy2 = it.yh + 1;
            if (ix1 < ix2 && iy1 < iy2) area += (ix2 - ix1) * (iy2 - iy1);
          end
      end
    end
    res.top  = top[HGT_W-1:0];
    res.area = area[AR_W-1:0];
  endtask

  // input side: one item in flight, random gap after each
  always @(posedge clk_i) begin : op_driver
    height_result_t want;
    region_op_t     nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_wait       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_region_op(cur_op, want);
        expected_results = {expected_results, want};
        ops_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_wait != 0) begin
          s_axis_tvalid <= 1'b0;
          tx_wait       <= tx_wait - 1;
        end else if (pending_ops.size() != 0) begin
          nxt = pending_ops.pop_front();
          cur_op        <= nxt;
          s_axis_tdata  <= chme_pkg::IN_W'(nxt);
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 9) == 0) tx_burst = !tx_burst;
          tx_wait <= tx_burst ? 0 : $urandom_range(0, 7);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side: hold tready low a random number of cycles once a result shows up
  always @(posedge clk_i) begin : result_check
    height_result_t got, want;
    int unsigned    w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[AR_W+HGT_W-1:0];
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result max_height %0d top_area %0d",
                   $time, got.top, got.area);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.area != 0) area_hits++;
        if (got.top !== want.top || got.area !== want.area) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result %0d: expected max_height %0d top_area %0d, got %0d %0d",
                     $time, results_checked, want.top, want.area, got.top, got.area);
        end
      end
      if ($urandom_range(0, 9) == 0) rx_burst = !rx_burst;
      w = rx_burst ? 0 : $urandom_range(0, 7);
      rx_wait       <= w;
      m_axis_tready <= (w == 0);
    end else if (m_axis_tvalid) begin
      if (rx_wait == 0) m_axis_tready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end else if (rx_wait == 0) begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("Timeout: nothing moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void queue_op(input logic [chme_pkg::OP_W-1:0] op, input int unsigned xl,
                                   input int unsigned yl, input int unsigned xh,
                                   input int unsigned yh, input int unsigned h);
    region_op_t it;
    it.op = op;
    it.xl = xl[CRD_W-1:0];
    it.yl = yl[CRD_W-1:0];
    it.xh = xh[CRD_W-1:0];
    it.yh = yh[CRD_W-1:0];
    it.h  = h[HGT_W-1:0];
    pending_ops = {pending_ops, it};
  endfunction

  // mostly small rectangles near the pallet; a few arbitrary ones span the grid
  function automatic region_op_t random_op();
    region_op_t  it;
    int unsigned pick, xlim, ylim, a, b;
    pick = $urandom_range(0, 99);
    if (pick < 35) it.op = chme_pkg::OP_ADD;
    else if (pick < 62) it.op = chme_pkg::OP_MAX;
    else if (pick < 92) it.op = chme_pkg::OP_AREA;
    else it.op = chme_pkg::OP_NONE;
    xlim = pallet_len + 15;
    if (xlim > 1023) xlim = 1023;
    ylim = pallet_wid + 15;
    if (ylim > 1023) ylim = 1023;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      it.xl = CRD_W'($urandom);
      it.yl = CRD_W'($urandom);
      it.xh = CRD_W'($urandom);
      it.yh = CRD_W'($urandom);
    end else begin
      a = $urandom_range(0, xlim);
      b = $urandom_range(0, ylim);
      it.xl = CRD_W'(a);
      it.yl = CRD_W'(b);
      if (pick == 1) begin
        // inverted, often inside one cell
        it.xh = CRD_W'((a < 15) ? 0 : a - $urandom_range(0, 15));
        it.yh = CRD_W'(b);
      end else begin
        a = a + $urandom_range(0, 47);
        b = b + $urandom_range(0, 47);
        it.xh = CRD_W'((a > 1023) ? 1023 : a);
        it.yh = CRD_W'((b > 1023) ? 1023 : b);
      end
    end
    pick = $urandom_range(0, 3);
    it.h = (pick == 3) ? HGT_W'($urandom) : HGT_W'(100 * (pick + 1));
    return it;
  endfunction

  task automatic write_cfg(input logic idx, input logic [EX_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == chme_pkg::CFG_LENGTH) pallet_len = value;
    else pallet_wid = value;
  endtask

  // sampled at the falling edge so queue and handshake updates have settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
  endtask

  initial begin : stimulus
    int unsigned len_set [8];
    int unsigned wid_set [8];
    int unsigned n_items;
    for (int i = 0; i < CELLS; i++) cell_h[i] = '0;
    len_set = '{2047, 0, 1024, 1, 200, 1024, 0, 0};
    wid_set = '{2047, 1024, 0, 1, 137, 1024, 0, 0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at the reset pallet size
    queue_op(chme_pkg::OP_AREA, 0, 0, 1023, 1023, 0);
    queue_op(chme_pkg::OP_ADD, 5, 7, 40, 20, 100);
    queue_op(chme_pkg::OP_ADD, 30, 10, 70, 50, 250);
    queue_op(chme_pkg::OP_MAX, 0, 0, 1023, 1023, 16'hFFFF);
    queue_op(chme_pkg::OP_AREA, 0, 0, 1023, 1023, 0);
    queue_op(chme_pkg::OP_AREA, 20, 15, 35, 40, 0);
    queue_op(chme_pkg::OP_ADD, 5, 7, 40, 20, 50);           // lower height leaves cells alone
    queue_op(chme_pkg::OP_AREA, 5, 7, 40, 20, 0);
    queue_op(chme_pkg::OP_ADD, 1000, 1000, 1023, 1023, 16'hFFFF);
    queue_op(chme_pkg::OP_AREA, 0, 0, 1023, 1023, 0);
    queue_op(chme_pkg::OP_MAX, 100, 0, 20, 1023, 16'hA5A5); // empty x span
    queue_op(chme_pkg::OP_AREA, 0, 100, 1023, 20, 0);       // empty y span
    queue_op(chme_pkg::OP_AREA, 40, 12, 35, 12, 0);         // inverted inside one cell
    queue_op(chme_pkg::OP_ADD, 40, 12, 35, 12, 300);
    queue_op(chme_pkg::OP_MAX, 32, 0, 47, 15, 0);
    queue_op(chme_pkg::OP_NONE, 0, 0, 1023, 1023, 16'hFFFF);
    queue_op(chme_pkg::OP_MAX, 0, 0, 1023, 1023, 0);
    queue_op(chme_pkg::OP_ADD, 0, 0, 1023, 1023, 0);
    queue_op(chme_pkg::OP_AREA, 1023, 1023, 1023, 1023, 0);
    queue_op(chme_pkg::OP_AREA, 0, 0, 0, 0, 0);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      if (p >= 6) begin
        len_set[p] = $urandom_range(1, 1024);
        wid_set[p] = $urandom_range(1, 1024);
      end
      write_cfg(chme_pkg::CFG_LENGTH, EX_W'(len_set[p]));
      write_cfg(chme_pkg::CFG_WIDTH, EX_W'(wid_set[p]));
      cfg_settings++;
      @(negedge clk_i);
      // with no rows or columns every span is empty, so keep those phases short
      n_items = (pallet_len == 0 || pallet_wid == 0) ? 5 : 14;
      for (int i = 0; i < n_items; i++) pending_ops = {pending_ops, random_op()};
      wait_idle();
    end

    repeat (ITEM_LATENCY) @(posedge clk_i);
    if (expected_results.size() != 0) mismatch_count += expected_results.size();
    $display("Covered %0d ops over %0d pallet settings; %0d results checked.",
             ops_accepted, cfg_settings, results_checked);
    $display("%0d area results had a nonzero top area; %0d mismatches.",
             area_hits, mismatch_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
